@@ rtl/blm_pkg.sv @@
`default_nettype none

package blm_pkg;

  // Action codes.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Access size codes; codes above SIZE_UBYTE touch nothing.
  localparam logic [2:0] SIZE_BYTE  = 3'd0;
  localparam logic [2:0] SIZE_HALF  = 3'd1;
  localparam logic [2:0] SIZE_WORD  = 3'd2;
  localparam logic [2:0] SIZE_UHALF = 3'd3;
  localparam logic [2:0] SIZE_UBYTE = 3'd4;

  localparam int unsigned LANES = 4;

  // Request state carried from the RAM read cycle to the result cycle.
  typedef struct packed {
    logic       write;
    logic [2:0] size;
    logic [1:0] lane_ofs;
    logic       err;
  } blm_req_t;

  // Number of bytes an access spans; the upper modes span a whole word.
  function automatic logic [2:0] size_span(input logic [2:0] size);
    logic [2:0] span;
    unique case (size)
      SIZE_BYTE:                          span = 3'd1;
      SIZE_HALF:                          span = 3'd2;
      SIZE_WORD, SIZE_UHALF, SIZE_UBYTE:  span = 3'd4;
      default:                            span = 3'd0;
    endcase
    return span;
  endfunction

  function automatic logic size_known(input logic [2:0] size);
    return (size <= SIZE_UBYTE);
  endfunction

endpackage

`default_nettype wire

@@ rtl/blm_ram.sv @@
`default_nettype none

module blm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/byte_lane_data_memory_unit.sv @@
// Channel      Ports                                   Handshake
// input        in_action, in_access_size,              accepted when start && !busy
//              in_byte_address, in_write_data
// result       out_read_data, out_range_error          out_valid for one cycle
//
// One transaction per cycle while busy is low: a result appears in the cycle after its
// transaction is accepted, set by the registered read of the four byte-lane RAMs.
// After reset busy stays high while a clearing pass zeroes one row of all lanes
// per cycle, over MEM_BYTES/4 rows (rounded up).
// The receiver cannot stall; busy is high only during the clearing pass.
`default_nettype none

module byte_lane_data_memory_unit
  import blm_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [2:0]  in_access_size,
  input  wire logic [31:0] in_byte_address,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  output logic [31:0]      out_read_data,
  output logic             out_range_error
);

  localparam int unsigned ROWS = (MEM_BYTES + 3) / 4;
  localparam int unsigned RW   = $clog2(ROWS);

  logic          clr_active_r;
  logic [RW-1:0] clr_row_r;
  logic          valid_r;
  blm_req_t      req_r;
  logic [31:0]   last_read_r;

  logic          accept;
  logic [2:0]    span;
  logic [32:0]   top_addr;
  logic          err;
  logic [1:0]    a_lo;
  logic [7:0]    lane_rd [LANES];
  logic [7:0]    rb [LANES];
  logic [31:0]   rd_value;
  logic [31:0]   result;
  logic          upd_last;

  assign accept = start && !busy;
  assign busy   = clr_active_r;
  assign span   = size_span(in_access_size);
  assign a_lo   = in_byte_address[1:0];

  assign top_addr = {1'b0, in_byte_address} + 33'(span) - 33'(span != 3'd0);
  assign err      = size_known(in_access_size) && (top_addr >= 33'(MEM_BYTES));

  // Each lane holds the bytes whose address is congruent to the lane index.
  // A read and a write to the same row never need forwarding: a write lands
  // at the edge that accepts it, before any later read is issued.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [1:0]    ofs;
    logic          touched;
    logic [RW-1:0] row;
    logic          we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;

    assign ofs     = 2'(l) - a_lo;
    assign touched = ({1'b0, ofs} < span);
    assign row     = in_byte_address[RW+1:2] + RW'(2'(l) < a_lo);

    assign re = accept && !err && (in_action == ACT_READ) && touched;
    assign we = clr_active_r ||
                (accept && !err && (in_action == ACT_WRITE) && touched &&
                 (in_access_size <= SIZE_WORD));
    assign waddr = clr_active_r ? clr_row_r : row;
    assign wdata = clr_active_r ? 8'h00 : in_write_data[8*ofs +: 8];

    blm_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (row),
      .rdata (lane_rd[l])
    );

    // Byte at offset l of the access, taken from whichever lane holds it.
    assign rb[l] = lane_rd[2'(req_r.lane_ofs + 2'(l))];
  end

  always_comb begin
    unique case (req_r.size)
      SIZE_BYTE:  rd_value = {24'h0, rb[0]};
      SIZE_HALF:  rd_value = {16'h0, rb[1], rb[0]};
      SIZE_WORD:  rd_value = {rb[3], rb[2], rb[1], rb[0]};
      SIZE_UHALF: rd_value = {rb[3], rb[2], 16'h0};
      SIZE_UBYTE: rd_value = {rb[3], 24'h0};
      default:    rd_value = last_read_r;
    endcase
  end

  assign upd_last = valid_r && !req_r.write && !req_r.err && size_known(req_r.size);
  assign result   = upd_last ? rd_value : last_read_r;

  assign out_valid       = valid_r;
  assign out_read_data   = result;
  assign out_range_error = valid_r && req_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
      valid_r      <= 1'b0;
      last_read_r  <= '0;
    end else begin
      if (clr_active_r) begin
        clr_row_r <= clr_row_r + RW'(1);
        if (clr_row_r == RW'(ROWS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      valid_r <= accept;
      if (upd_last) begin
        last_read_r <= rd_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.write    <= (in_action == ACT_WRITE);
      req_r.size     <= in_access_size;
      req_r.lane_ofs <= a_lo;
      req_r.err      <= err;
    end
  end

endmodule

`default_nettype wire

@@ rtl/blm_checker.sv @@
`default_nettype none

module blm_checker
  import blm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  in_access_size,
  input wire logic        out_valid,
  input wire logic        out_range_error
);

  // The clearing pass starts right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !$past(rst_n) && rst_n |-> busy)
    else $error("busy low after reset");

  // Once the clearing pass is done, busy never returns without reset.
  a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy rose outside reset");

  // Every accepted transaction gives its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("missing result");

  // No result without a transaction accepted in the previous cycle.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without transaction");

  // Unknown sizes touch nothing and are never out of range.
  a_unknown_size: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !size_known(in_access_size) |=> !out_range_error)
    else $error("range error on unknown size");

endmodule

bind byte_lane_data_memory_unit blm_checker u_blm_checker (.*);

`default_nettype wire
